// File: src/ddd_pkg.sv
// dihedral duplicate detector package: sizes, payload structs, state enum
// no dependencies
`default_nettype none
package ddd_pkg;
  localparam int NumBuckets  = 8192;
  localparam int BucketDepth = 4;
  localparam int ValueBits   = 24;
  localparam int Ring        = 6;
  localparam int BucketBits  = $clog2(NumBuckets);
  localparam int SlotBits    = (BucketDepth > 1) ? $clog2(BucketDepth) : 1;
  localparam int FillBits    = $clog2(BucketDepth + 1);
  localparam int EntryBits   = BucketBits + SlotBits;
  localparam int RecBits     = Ring * ValueBits;

  typedef struct packed {
    logic [23:0] value_5;
    logic [23:0] value_4;
    logic [23:0] value_3;
    logic [23:0] value_2;
    logic [23:0] value_1;
    logic [23:0] value_0;
  } in_item_t;

  typedef struct packed {
    logic twin_seen;
    logic this_matched;
    logic bucket_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_HASH, ST_FILL, ST_SCAN, ST_DONE
  } state_t;
endpackage
`default_nettype wire

// File: src/dihedral_duplicate_detector.sv
// dihedral duplicate detector top level: hash, fill memory, record memory
// depends on ddd_pkg
`default_nettype none
// Records of six values are hashed by their sum modulo the bucket count and
// compared, one stored record per cycle, against the records held in that
// bucket under rotation and reflection. An unmatched record is appended
// unless the bucket is full. An item passes through states that take the
// transfer, hash, read the fill, scan the bucket and finish, in that order.
// The scan reads the stored records one at a time, because the record memory
// has a single read port, and ends early when a match is found. After reset
// a clearing pass zeroes the fill memory, one bucket a cycle, before the
// first item is taken. A result waits in an output register while the next
// item is taken and processed. That item holds in its last cycle until the
// waiting result is transferred.
module dihedral_duplicate_detector (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ddd_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ddd_pkg::out_item_t out_data
);
  import ddd_pkg::*;

  logic [FillBits-1:0]  fill_mem [NumBuckets];
  logic [RecBits-1:0]   rec_mem  [NumBuckets*BucketDepth];

  state_t               state_r, state_nxt;
  logic [BucketBits-1:0] clr_r, clr_nxt;
  logic [RecBits-1:0]   rec_r;
  logic [BucketBits-1:0] bucket_r;
  logic [FillBits-1:0]  fill_rd, fill_r;
  logic [FillBits-1:0]  slot_r, slot_nxt;
  logic [RecBits-1:0]   ent_rd;
  logic                 ent_vld_r;
  logic                 match_r, match_nxt;
  logic                 twin_r, twin_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic                 fill_we;
  logic [BucketBits-1:0] fill_wa;
  logic [FillBits-1:0]  fill_wd;
  logic                 rec_we;
  logic [EntryBits-1:0] rec_ra;
  logic [ValueBits+2:0] sum;
  logic                 eq;

  // record read port, address advances with slot
  assign rec_ra = {bucket_r, slot_r[SlotBits-1:0]};

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_rd <= fill_mem[sum[BucketBits-1:0]];
    if (rec_we) rec_mem[{bucket_r, fill_r[SlotBits-1:0]}] <= rec_r;
    ent_rd <= rec_mem[rec_ra];
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < Ring; i++)
      sum = sum + (ValueBits+3)'(rec_r[i*ValueBits +: ValueBits]);
  end

  // ring compare against entry under all 12 symmetries
  always_comb begin
    logic f, b;
    eq = 1'b0;
    for (int s = 0; s < Ring; s++) begin
      f = 1'b1;
      b = 1'b1;
      for (int j = 0; j < Ring; j++) begin
        if (rec_r[j*ValueBits +: ValueBits] != ent_rd[((s+j)%Ring)*ValueBits +: ValueBits])
          f = 1'b0;
        if (rec_r[j*ValueBits +: ValueBits] !=
            ent_rd[((s+Ring-j)%Ring)*ValueBits +: ValueBits])
          b = 1'b0;
      end
      if (f || b) eq = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      slot_r      <= '0;
      ent_vld_r   <= 1'b0;
      match_r     <= 1'b0;
      twin_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      slot_r      <= slot_nxt;
      ent_vld_r   <= (state_r == ST_SCAN) && (slot_r < fill_r) && !match_nxt;
      match_r     <= match_nxt;
      twin_r      <= twin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) rec_r <= in_data;
    if (state_r == ST_HASH) bucket_r <= sum[BucketBits-1:0];
    if (state_r == ST_FILL) fill_r <= (fill_rd > FillBits'(BucketDepth)) ?
                                      FillBits'(BucketDepth) : fill_rd;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    match_nxt     = match_r;
    twin_nxt      = twin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    fill_we       = 1'b0;
    fill_wa       = clr_r;
    fill_wd       = '0;
    rec_we        = 1'b0;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        fill_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BucketBits'(NumBuckets-1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_HASH;
      end
      ST_HASH: state_nxt = ST_FILL;   // fill read issues from the sum
      ST_FILL: begin
        slot_nxt  = '0;
        match_nxt = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // compare the entry read last cycle
        if (ent_vld_r && eq) match_nxt = 1'b1;
        if (match_nxt || (slot_r >= fill_r && !ent_vld_r)) state_nxt = ST_DONE;
        else if (slot_r < fill_r) slot_nxt = slot_r + 1'b1;
      end
      ST_DONE: begin
        // hold while the previous result still waits
        if (!out_valid_r || !out_stall) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.this_matched = match_r;
          out_data_nxt.bucket_full  = !match_r && (fill_r == FillBits'(BucketDepth));
          out_data_nxt.twin_seen    = twin_r | match_r;
          twin_nxt = twin_r | match_r;
          if (!match_r && fill_r != FillBits'(BucketDepth)) begin
            rec_we  = 1'b1;
            fill_we = 1'b1;
            fill_wa = bucket_r;
            fill_wd = fill_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.bucket_full && out_data.this_matched))
    else $error("full and matched together");
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(twin_r) && rst_n && $past(rst_n) |-> twin_r)
    else $error("twin flag dropped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input taken while busy");
`endif
endmodule
`default_nettype wire
